// ===== sv/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg: shared definitions for the scaled playback clock
// Widths, the clock state record and the reading clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

  localparam int TIME_BITS       = 48;
  localparam int SPEED_FRAC_BITS = 12;
  localparam int SPEED_W         = 16;
  localparam int TOL_W           = 16;
  localparam int OFFSET_W        = 32;
  localparam int THR_W           = TOL_W + SPEED_W;

  // scaled elapsed magnitude, then signed reading with headroom for the sums
  localparam int PROD_W = TIME_BITS + SPEED_W;
  localparam int SC_W   = PROD_W - SPEED_FRAC_BITS;
  localparam int NOW_W  = SC_W + 2;

  localparam int IN_DATA_W  = ((2 * TIME_BITS + SPEED_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((TIME_BITS - 1 + 7) / 8) * 8;

  localparam logic [TIME_BITS-1:0] CLOCK_MAX  = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam logic [SPEED_W-1:0]   SPEED_ONE  = SPEED_W'(1) << SPEED_FRAC_BITS;
  localparam logic [SPEED_W-1:0]   SPEED_HALF = SPEED_W'(1) << (SPEED_FRAC_BITS - 1);
  localparam logic [TOL_W-1:0]     SLOW_TOL   = TOL_W'(5000);
  localparam logic [TOL_W-1:0]     TOL_RESET  = TOL_W'(50);

  typedef struct packed {
    logic                 running;
    logic [TIME_BITS-1:0] base_time;
    logic [TIME_BITS-1:0] anchor_sys;
    logic [TIME_BITS-1:0] held_time;
    logic [SPEED_W-1:0]   speed;
    logic                 slow_mode;
  } spc_state_t;

  // floor a running reading at 1 and cap it at the largest clock value
  function automatic logic [TIME_BITS-1:0] clamp_time(input logic signed [NOW_W-1:0] v);
    logic signed [NOW_W-1:0] lim;
    lim = $signed({{(NOW_W-TIME_BITS){1'b0}}, CLOCK_MAX});
    if (v <= 0) begin
      return TIME_BITS'(1);
    end else if (v > lim) begin
      return CLOCK_MAX;
    end else begin
      return v[TIME_BITS-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/spc_reader.sv =====
// ----------------------------------------------------------------------------
// spc_reader: current clock reading (held value while paused, 0 if unset)
// Running: base plus the speed-scaled elapsed time, less the display offset.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_reader (
  input  spc_pkg::spc_state_t                st,
  input  logic [spc_pkg::TIME_BITS-1:0]      sys_time,
  input  logic signed [spc_pkg::OFFSET_W-1:0] display_offset,
  output logic [spc_pkg::TIME_BITS-1:0]      reading
);
  import spc_pkg::*;

  logic                    ahead;
  logic [TIME_BITS-1:0]    mag;
  logic [PROD_W-1:0]       prod;
  logic [SC_W-1:0]         scaled;
  logic signed [NOW_W-1:0] elapsed;
  logic signed [NOW_W-1:0] now;

  assign ahead   = sys_time >= st.anchor_sys;
  assign mag     = ahead ? sys_time - st.anchor_sys : st.anchor_sys - sys_time;
  assign prod    = PROD_W'(mag) * PROD_W'(st.speed);
  assign scaled  = prod[PROD_W-1:SPEED_FRAC_BITS];
  // truncate on the magnitude, then apply the sign
  assign elapsed = ahead ? $signed({2'b00, scaled}) : -$signed({2'b00, scaled});
  assign now     = $signed({{(NOW_W-TIME_BITS){1'b0}}, st.base_time}) + elapsed
                   - NOW_W'(display_offset);

  always_comb begin
    if (!st.running) begin
      reading = st.held_time;
    end else if (st.base_time == '0) begin
      reading = '0;
    end else begin
      reading = clamp_time(now);
    end
  end

endmodule

`default_nettype wire

// ===== sv/scaled_playback_clock.sv =====
// ----------------------------------------------------------------------------
// scaled_playback_clock: speed-scaled playback clock
// Applies read, set time, set speed, start and pause events to a playback
// clock and returns the clock reading after each event.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  s_*      | in        | tuser: op; tdata: sys_time, new_time, new_speed
//  m_*      | out       | tdata: clock_time; tuser: status, paused
//  APB      | in/out    | 0x0 resync_tolerance, 0x4 display_offset
//
// One event per cycle sustained while results are taken; an event passes
// through the input register, then the result register. The path between them
// is the 48x16 elapsed-time multiplier in spc_reader followed by the offset
// adds, the resync compare and the state update.
// Reset (rst, synchronous) leaves the clock unset and paused at speed 1.0 with
// the register defaults. A stalled result holds in the result register; the
// input register keeps taking events until both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_playback_clock (
  input  logic                             clk,
  input  logic                             rst,
  // input events
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [2:0]                       s_tuser,  // [2:0] op
  // [47:0] sys_time, [95:48] new_time, [111:96] new_speed
  input  logic [spc_pkg::IN_DATA_W-1:0]    s_tdata,
  // results
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [spc_pkg::OUT_DATA_W-1:0]   m_tdata,  // [46:0] clock_time, [47] zero
  output logic [1:0]                       m_tuser,  // [0] status, [1] paused
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import spc_pkg::*;

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_SET_TIME  = 3'd1,
    OP_SET_SPEED = 3'd2,
    OP_START     = 3'd3,
    OP_PAUSE     = 3'd4
  } op_t;

  typedef enum logic {
    REG_TOLERANCE = 1'b0,
    REG_OFFSET    = 1'b1
  } reg_idx_t;

  // configuration registers
  logic [TOL_W-1:0]           resync_tolerance;
  logic signed [OFFSET_W-1:0] display_offset;

  // input register
  logic                  in_valid;
  logic [2:0]            in_op;
  logic [TIME_BITS-1:0]  in_sys;
  logic [TIME_BITS-1:0]  in_new_time;
  logic [SPEED_W-1:0]    in_new_speed;

  // clock state
  spc_state_t st, st_next;

  logic                  advance;
  logic [TIME_BITS-1:0]  cur;
  logic                  status_next;
  logic [TIME_BITS-1:0]  post_direct;
  logic [TIME_BITS-1:0]  sub_src;
  logic                  use_sub;
  logic [TIME_BITS-1:0]  sub_val;
  logic signed [NOW_W-1:0] sub_now;
  logic [TIME_BITS-1:0]  post;

  // resync window
  logic [TOL_W-1:0]          tol_eff;
  logic [THR_W-1:0]          thr;
  logic [THR_W-1:0]          win;
  logic signed [TIME_BITS-1:0] target;
  logic signed [TIME_BITS+1:0] delta;
  logic [TIME_BITS:0]        diff;
  logic                      resync_skip;
  logic [TIME_BITS-1:0]      tgt;

  assign pready = 1'b1;

  // APB write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      resync_tolerance <= TOL_RESET;
      display_offset   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_TOLERANCE: resync_tolerance <= pwdata[TOL_W-1:0];
        REG_OFFSET:    display_offset   <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOLERANCE: prdata = {{(32-TOL_W){1'b0}}, resync_tolerance};
      REG_OFFSET:    prdata = display_offset;
      default:       prdata = '0;
    endcase
  end

  // advance the event into the result register when that slot is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op        <= s_tuser;
      in_sys       <= s_tdata[TIME_BITS-1:0];
      in_new_time  <= s_tdata[2*TIME_BITS-1:TIME_BITS];
      in_new_speed <= s_tdata[2*TIME_BITS+SPEED_W-1:2*TIME_BITS];
    end
  end

  // reading before the event
  spc_reader u_reader (
    .st             (st),
    .sys_time       (in_sys),
    .display_offset (display_offset),
    .reading        (cur)
  );

  // set time is dropped while the jump stays inside tolerance * speed
  assign tol_eff = st.slow_mode ? SLOW_TOL : resync_tolerance;
  assign thr     = THR_W'(tol_eff) * THR_W'(st.speed);
  assign win     = (thr - THR_W'(1)) >> SPEED_FRAC_BITS;
  assign target  = $signed(in_new_time);
  assign delta   = (TIME_BITS+2)'(target) - $signed({2'b00, cur});
  assign diff    = delta[TIME_BITS+1] ? (TIME_BITS+1)'(0) - delta[TIME_BITS:0]
                                      : delta[TIME_BITS:0];
  assign resync_skip = (st.base_time != '0) && (thr != '0)
                       && (diff <= {{(TIME_BITS+1-THR_W){1'b0}}, win});
  assign tgt = (target <= 0) ? TIME_BITS'(1) : target[TIME_BITS-1:0];

  always_comb begin
    st_next     = st;
    status_next = 1'b0;
    post_direct = cur;
    sub_src     = cur;
    use_sub     = 1'b0;
    unique case (in_op)
      OP_SET_TIME: begin
        if (!resync_skip) begin
          st_next.base_time  = tgt;
          st_next.anchor_sys = in_sys;
          st_next.held_time  = tgt;
          post_direct        = tgt;
          sub_src            = tgt;
          use_sub            = st.running;
        end
      end
      OP_SET_SPEED: begin
        if (in_new_speed == '0) begin
          status_next = 1'b1;
        end else begin
          st_next.base_time  = cur;
          st_next.anchor_sys = in_sys;
          st_next.held_time  = cur;
          st_next.speed      = in_new_speed;
          st_next.slow_mode  = in_new_speed < SPEED_HALF;
          use_sub            = st.running;
        end
      end
      OP_START: begin
        if (!st.running) begin
          st_next.running    = 1'b1;
          st_next.base_time  = st.held_time;
          st_next.anchor_sys = in_sys;
          sub_src            = st.held_time;
          use_sub            = 1'b1;
        end
      end
      OP_PAUSE: begin
        st_next.held_time = (cur == '0) ? TIME_BITS'(1) : cur;
        st_next.running   = 1'b0;
        post_direct       = st_next.held_time;
      end
      default: ;  // read and unused codes
    endcase
  end

  // re-read after a rebase: elapsed time is zero, only the offset applies
  assign sub_now = $signed({{(NOW_W-TIME_BITS){1'b0}}, sub_src}) - NOW_W'(display_offset);
  assign sub_val = (sub_src == '0) ? '0 : clamp_time(sub_now);
  assign post    = use_sub ? sub_val : post_direct;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.running    <= 1'b0;
      st.base_time  <= '0;
      st.anchor_sys <= '0;
      st.held_time  <= '0;
      st.speed      <= SPEED_ONE;
      st.slow_mode  <= 1'b0;
      m_tvalid      <= 1'b0;
    end else if (advance) begin
      st       <= st_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= OUT_DATA_W'({1'b0, post[TIME_BITS-2:0]});
      m_tuser <= {!st_next.running, status_next};
    end
  end

endmodule

`default_nettype wire

// ===== sv/spc_checker.sv =====
// ----------------------------------------------------------------------------
// spc_port_checks: port-level checks for the scaled playback clock
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_port_checks (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [spc_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]                     m_tuser
);
  import spc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // input back-pressure only comes from a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a stalled result");

  // a reading never exceeds the largest clock value
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TIME_BITS-1] == 1'b0)
    else $error("clock reading out of range");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind scaled_playback_clock spc_port_checks u_spc_port_checks (.*);

`default_nettype wire
